// ----- rtl/core/pnmbgr_pkg.sv -----
package pnmbgr_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL     = 2'd0;
  localparam logic [1:0] KIND_HEADER    = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

  // header characters
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_SIX  = 8'h36;
  localparam logic [7:0] CH_FIVE = 8'h35;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // one result beat
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_pixel;
  } res_t;

endpackage

// ----- rtl/core/pnmbgr_in_if.sv -----
interface pnmbgr_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_file;
  logic [7:0] data_byte;

  modport source (output valid, output start_of_file, output data_byte, input ready);
  modport sink   (input valid, input start_of_file, input data_byte, output ready);
endinterface

// ----- rtl/core/pnmbgr_out_if.sv -----
interface pnmbgr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        last_pixel;

  modport source (output valid, output result_kind, output blue, output green, output red,
                  output image_width, output image_height, output last_pixel, input ready);
  modport sink   (input valid, input result_kind, input blue, input green, input red,
                  input image_width, input image_height, input last_pixel, output ready);
endinterface

// ----- rtl/core/pnm_byte_stream_to_bgrx_pixels_core.sv -----
// Channel  Dir  Payload                                            Beat
// in_bus   in   start_of_file, data_byte                          one file byte
// out_bus  out  result_kind, blue, green, red, image_width,       one result
//               image_height, last_pixel
//
// One byte per cycle sustained while the output is not stalled; each byte waits
// in the input register and its result, if any, is loaded into the output register
// when the byte advances. The parser step between the two registers sets the rate.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to waiting for the magic.
// A stalled output holds its beat; the input register still takes a byte while
// the output register is free or being drained, or while the input register is empty.
module pnm_byte_stream_to_bgrx_pixels_core #(
  parameter int DIM_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  pnmbgr_in_if.sink    in_bus,
  pnmbgr_out_if.source out_bus
);

  logic             in_vld_r;
  logic             in_sof_r;
  logic [7:0]       in_byte_r;
  logic             out_vld_r;
  pnmbgr_pkg::res_t out_res_r;
  logic             advance;
  logic             res_vld;
  pnmbgr_pkg::res_t res;

  // move a byte from the input register through the parser
  assign advance      = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !in_vld_r || advance;

  pnmbgr_dec #(
    .DIM_BITS (DIM_BITS)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .sof     (in_sof_r),
    .byte_in (in_byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // capture input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_sof_r  <= in_bus.start_of_file;
      in_byte_r <= in_bus.data_byte;
    end
  end

  // load or drain output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_vld;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid        = out_vld_r;
  assign out_bus.result_kind  = out_res_r.result_kind;
  assign out_bus.blue         = out_res_r.blue;
  assign out_bus.green        = out_res_r.green;
  assign out_bus.red          = out_res_r.red;
  assign out_bus.image_width  = out_res_r.image_width;
  assign out_bus.image_height = out_res_r.image_height;
  assign out_bus.last_pixel   = out_res_r.last_pixel;

  // last pixel flag only on pixel beats
  a_last_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.last_pixel |-> out_res_r.result_kind == pnmbgr_pkg::KIND_PIXEL)
    else $error("last_pixel set on a non-pixel result");

  // header and error beats carry no color
  a_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.result_kind != pnmbgr_pkg::KIND_PIXEL |->
      out_res_r.blue == 8'd0 && out_res_r.green == 8'd0 && out_res_r.red == 8'd0)
    else $error("color on a non-pixel result");

  // bad magic beat carries no dimensions
  a_err_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.result_kind == pnmbgr_pkg::KIND_BAD_MAGIC |->
      out_res_r.image_width == 16'd0 && out_res_r.image_height == 16'd0)
    else $error("dimensions on a bad magic result");

  // a held byte with a blocked output must not advance
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_bus.ready |=> in_vld_r && $stable(in_byte_r))
    else $error("input register lost a byte under stall");

endmodule

// ----- rtl/core/pnmbgr_dec.sv -----
module pnmbgr_dec #(
  parameter int DIM_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              sof,
  input  logic [7:0]        byte_in,
  output logic              res_vld,
  output pnmbgr_pkg::res_t  res
);

  localparam int EXT_BITS = DIM_BITS + 16;
  localparam int ACC_BITS = DIM_BITS + 4;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

  typedef enum logic [3:0] {
    PH_MAGIC_P, PH_MAGIC_T, PH_SEEK_EOL, PH_LINE, PH_WIDTH, PH_SEEK_H,
    PH_HEIGHT, PH_SEEK_D, PH_DEPTH, PH_PIXELS, PH_DONE, PH_ERROR
  } phase_t;

  phase_t              phase_r, phase_nxt, phase_cur;
  logic                color_r, color_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [7:0]          red_r, red_nxt;
  logic [7:0]          green_r, green_nxt;
  logic [1:0]          bip_r, bip_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;

  logic                is_digit;
  logic [7:0]          dsub;
  logic [3:0]          dval;
  logic [DIM_BITS:0]   col_inc, row_inc;
  logic                row_end, img_end;
  logic [EXT_BITS-1:0] w_ext, h_ext;

  // decimal accumulate with saturation at the field maximum
  function automatic logic [DIM_BITS-1:0] acc(input logic [DIM_BITS-1:0] v,
                                              input logic [3:0] d);
    logic [ACC_BITS-1:0] ve;
    logic [ACC_BITS-1:0] sum;
    ve  = ACC_BITS'(v);
    sum = (ve << 3) + (ve << 1) + ACC_BITS'(d);
    if (sum > ACC_BITS'(DIM_MAX)) begin
      return DIM_MAX;
    end
    return sum[DIM_BITS-1:0];
  endfunction

  assign is_digit  = byte_in inside {[pnmbgr_pkg::CH_ZERO:pnmbgr_pkg::CH_NINE]};
  assign dsub      = byte_in - pnmbgr_pkg::CH_ZERO;
  assign dval      = dsub[3:0];
  assign phase_cur = sof ? PH_MAGIC_P : phase_r;

  // position in the image
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign row_end = col_inc >= {1'b0, width_r};
  assign img_end = row_end && (row_inc >= {1'b0, height_r});

  assign w_ext = EXT_BITS'(width_r);
  assign h_ext = EXT_BITS'(height_r);

  // step the parser on one byte
  always_comb begin
    phase_nxt  = phase_cur;
    color_nxt  = sof ? 1'b0 : color_r;
    width_nxt  = sof ? '0 : width_r;
    height_nxt = sof ? '0 : height_r;
    red_nxt    = sof ? '0 : red_r;
    green_nxt  = sof ? '0 : green_r;
    bip_nxt    = sof ? '0 : bip_r;
    col_nxt    = sof ? '0 : col_r;
    row_nxt    = sof ? '0 : row_r;

    res_vld          = 1'b0;
    res.result_kind  = pnmbgr_pkg::KIND_PIXEL;
    res.blue         = '0;
    res.green        = '0;
    res.red          = '0;
    res.image_width  = w_ext[15:0];
    res.image_height = h_ext[15:0];
    res.last_pixel   = 1'b0;

    case (phase_cur)
      PH_MAGIC_P: begin
        if (byte_in == pnmbgr_pkg::CH_P) begin
          phase_nxt = PH_MAGIC_T;
        end else begin
          phase_nxt = PH_ERROR;
          res_vld   = 1'b1;
        end
      end
      PH_MAGIC_T: begin
        if (byte_in inside {pnmbgr_pkg::CH_SIX, pnmbgr_pkg::CH_FIVE}) begin
          color_nxt = (byte_in == pnmbgr_pkg::CH_SIX);
          phase_nxt = PH_SEEK_EOL;
        end else begin
          phase_nxt = PH_ERROR;
          res_vld   = 1'b1;
        end
      end
      PH_SEEK_EOL: begin
        if (byte_in == pnmbgr_pkg::CH_LF) begin
          phase_nxt = PH_LINE;
        end
      end
      PH_LINE: begin
        if (byte_in == pnmbgr_pkg::CH_HASH) begin
          phase_nxt = PH_SEEK_EOL;
        end else if (is_digit) begin
          width_nxt = DIM_BITS'(dval);
          phase_nxt = PH_WIDTH;
        end else begin
          width_nxt = '0;
          phase_nxt = PH_SEEK_H;
        end
      end
      PH_WIDTH: begin
        if (is_digit) begin
          width_nxt = acc(width_r, dval);
        end else begin
          phase_nxt = PH_SEEK_H;
        end
      end
      PH_SEEK_H: begin
        if (is_digit) begin
          height_nxt = DIM_BITS'(dval);
          phase_nxt  = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (is_digit) begin
          height_nxt = acc(height_r, dval);
        end else begin
          phase_nxt = PH_SEEK_D;
        end
      end
      PH_SEEK_D: begin
        if (is_digit) begin
          phase_nxt = PH_DEPTH;
        end
      end
      PH_DEPTH: begin
        if (byte_in == pnmbgr_pkg::CH_LF) begin
          col_nxt         = '0;
          row_nxt         = '0;
          bip_nxt         = '0;
          phase_nxt       = (width_r == '0 || height_r == '0) ? PH_DONE : PH_PIXELS;
          res_vld         = 1'b1;
          res.result_kind = pnmbgr_pkg::KIND_HEADER;
        end
      end
      PH_PIXELS: begin
        if (!color_r || bip_r == 2'd2) begin
          // emit one pixel
          res_vld        = 1'b1;
          res.blue       = byte_in;
          res.green      = color_r ? green_r : byte_in;
          res.red        = color_r ? red_r : byte_in;
          res.last_pixel = img_end;
          bip_nxt        = '0;
          if (img_end) begin
            phase_nxt = PH_DONE;
          end else if (row_end) begin
            col_nxt = '0;
            row_nxt = row_inc[DIM_BITS-1:0];
          end else begin
            col_nxt = col_inc[DIM_BITS-1:0];
          end
        end else if (bip_r == 2'd0) begin
          red_nxt = byte_in;
          bip_nxt = 2'd1;
        end else begin
          green_nxt = byte_in;
          bip_nxt   = 2'd2;
        end
      end
      default: begin
      end
    endcase

    // bad magic carries no dimensions
    if (res.result_kind == pnmbgr_pkg::KIND_PIXEL && res_vld && phase_nxt == PH_ERROR) begin
      res.result_kind  = pnmbgr_pkg::KIND_BAD_MAGIC;
      res.image_width  = '0;
      res.image_height = '0;
    end
  end

  // hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC_P;
      color_r  <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      red_r    <= '0;
      green_r  <= '0;
      bip_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      color_r  <= color_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      bip_r    <= bip_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ----- bench/tb_pnm_byte_stream_to_bgrx_pixels_core.sv -----
`timescale 1ns / 100ps

module tb_pnm_byte_stream_to_bgrx_pixels_core;

  localparam int unsigned DIM_MAX     = 65535;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          ITEM_GOAL   = 850;
  localparam int          HOLD_CYCLES = 300;

  // one byte offered to the block, with an optional hand-typed result
  typedef struct packed {
    logic             sof;
    logic [7:0]       data;
    logic             fixed;
    pnmbgr_pkg::res_t want;
  } stim_row_t;

  localparam pnmbgr_pkg::res_t NO_RES = '0;

  typedef enum logic [3:0] {
    DEC_MAGIC_P, DEC_MAGIC_T, DEC_SKIP_LINE, DEC_LINE_START, DEC_WIDTH, DEC_FIND_H,
    DEC_HEIGHT, DEC_FIND_DEPTH, DEC_DEPTH, DEC_PIXELS, DEC_DONE, DEC_ERROR
  } dec_phase_t;

  logic clk;
  logic rst_n;

  pnmbgr_in_if  in_bus();
  pnmbgr_out_if out_bus();

  pnm_byte_stream_to_bgrx_pixels_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // decoder shadow state
  dec_phase_t  dec_phase;
  bit          dec_color;
  int unsigned dec_width;
  int unsigned dec_height;
  logic [7:0]  dec_red;
  logic [7:0]  dec_green;
  int unsigned dec_byte_idx;
  int unsigned dec_col;
  int unsigned dec_row;

  pnmbgr_pkg::res_t due_results_q[$];
  stim_row_t        stim_q[$];
  stim_row_t        cur_row;

  int err_count;
  int quiet_cycles;
  int results_seen;
  int pixels_seen;
  int headers_seen;
  int bad_magic_seen;
  int items_sent;
  int files_sent;
  int burst_left;
  bit steady_in;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_dec(logic [7:0] b);
    return b inside {[pnmbgr_pkg::CH_ZERO:pnmbgr_pkg::CH_NINE]};
  endfunction

  // append one decimal digit, pinning at the largest dimension
  function automatic int unsigned add_digit(int unsigned v, logic [7:0] b);
    int unsigned d;
    d = b - pnmbgr_pkg::CH_ZERO;
    if (v > (DIM_MAX - d) / 10) return DIM_MAX;
    return v * 10 + d;
  endfunction

  function automatic pnmbgr_pkg::res_t res_of(logic [1:0] kind, logic [7:0] bl,
                                              logic [7:0] gn, logic [7:0] rd,
                                              logic [15:0] wd, logic [15:0] ht,
                                              logic last);
    pnmbgr_pkg::res_t r;
    r.result_kind  = kind;
    r.blue         = bl;
    r.green        = gn;
    r.red          = rd;
    r.image_width  = wd;
    r.image_height = ht;
    r.last_pixel   = last;
    return r;
  endfunction

  task automatic clear_decoder();
    dec_phase    = DEC_MAGIC_P;
    dec_color    = 1'b0;
    dec_width    = 0;
    dec_height   = 0;
    dec_red      = '0;
    dec_green    = '0;
    dec_byte_idx = 0;
    dec_col      = 0;
    dec_row      = 0;
  endtask

  // build a pixel beat and advance the column / row position
  task automatic finish_pixel(input logic [7:0] rd, input logic [7:0] gn,
                              input logic [7:0] bl, output pnmbgr_pkg::res_t r);
    bit end_col;
    bit last_one;
    end_col  = dec_col + 1 >= dec_width;
    last_one = end_col && (dec_row + 1 >= dec_height);
    r = res_of(pnmbgr_pkg::KIND_PIXEL, bl, gn, rd, dec_width[15:0], dec_height[15:0],
               last_one);
    if (last_one) begin
      dec_phase = DEC_DONE;
    end else if (end_col) begin
      dec_col = 0;
      dec_row++;
    end else begin
      dec_col++;
    end
  endtask

  // one accepted file byte through the header parser / pixel packer
  task automatic decode_byte(input logic sof, input logic [7:0] b,
                             output bit made, output pnmbgr_pkg::res_t r);
    made = 1'b0;
    r    = NO_RES;
    if (sof) clear_decoder();
    case (dec_phase)
      DEC_MAGIC_P: begin
        if (b == pnmbgr_pkg::CH_P) begin
          dec_phase = DEC_MAGIC_T;
        end else begin
          dec_phase = DEC_ERROR;
          made = 1'b1;
          r.result_kind = pnmbgr_pkg::KIND_BAD_MAGIC;
        end
      end
      DEC_MAGIC_T: begin
        if (b inside {pnmbgr_pkg::CH_SIX, pnmbgr_pkg::CH_FIVE}) begin
          dec_color = (b == pnmbgr_pkg::CH_SIX);
          dec_phase = DEC_SKIP_LINE;
        end else begin
          dec_phase = DEC_ERROR;
          made = 1'b1;
          r.result_kind = pnmbgr_pkg::KIND_BAD_MAGIC;
        end
      end
      DEC_SKIP_LINE: if (b == pnmbgr_pkg::CH_LF) dec_phase = DEC_LINE_START;
      DEC_LINE_START: begin
        if (b == pnmbgr_pkg::CH_HASH) begin
          dec_phase = DEC_SKIP_LINE;
        end else if (is_dec(b)) begin
          dec_width = b - pnmbgr_pkg::CH_ZERO;
          dec_phase = DEC_WIDTH;
        end else begin
          dec_width = 0;
          dec_phase = DEC_FIND_H;
        end
      end
      DEC_WIDTH: begin
        if (is_dec(b)) dec_width = add_digit(dec_width, b);
        else dec_phase = DEC_FIND_H;
      end
      DEC_FIND_H: begin
        if (is_dec(b)) begin
          dec_height = b - pnmbgr_pkg::CH_ZERO;
          dec_phase  = DEC_HEIGHT;
        end
      end
      DEC_HEIGHT: begin
        if (is_dec(b)) dec_height = add_digit(dec_height, b);
        else dec_phase = DEC_FIND_DEPTH;
      end
      DEC_FIND_DEPTH: if (is_dec(b)) dec_phase = DEC_DEPTH;
      DEC_DEPTH: begin
        if (b == pnmbgr_pkg::CH_LF) begin
          dec_col      = 0;
          dec_row      = 0;
          dec_byte_idx = 0;
          dec_phase    = (dec_width == 0 || dec_height == 0) ? DEC_DONE : DEC_PIXELS;
          made = 1'b1;
          r = res_of(pnmbgr_pkg::KIND_HEADER, 8'd0, 8'd0, 8'd0, dec_width[15:0],
                     dec_height[15:0], 1'b0);
        end
      end
      DEC_PIXELS: begin
        if (!dec_color) begin
          made = 1'b1;
          finish_pixel(b, b, b, r);
        end else if (dec_byte_idx == 0) begin
          dec_red      = b;
          dec_byte_idx = 1;
        end else if (dec_byte_idx == 1) begin
          dec_green    = b;
          dec_byte_idx = 2;
        end else begin
          dec_byte_idx = 0;
          made = 1'b1;
          finish_pixel(dec_red, dec_green, b, r);
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // predict on every input beat, compare on every output beat
  always @(posedge clk) begin
    pnmbgr_pkg::res_t want;
    bit               made;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        decode_byte(in_bus.start_of_file, in_bus.data_byte, made, want);
        if (cur_row.fixed) begin
          made = 1'b1;
          want = cur_row.want;
        end
        if (made) due_results_q.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (due_results_q.size() == 0) begin
          $display("%0t: result beat of kind %0d with nothing expected", $time,
                   out_bus.result_kind);
          err_count++;
        end else begin
          want = due_results_q.pop_front();
          check_field("result_kind", want.result_kind, out_bus.result_kind);
          check_field("blue", want.blue, out_bus.blue);
          check_field("green", want.green, out_bus.green);
          check_field("red", want.red, out_bus.red);
          check_field("image_width", want.image_width, out_bus.image_width);
          check_field("image_height", want.image_height, out_bus.image_height);
          check_field("last_pixel", want.last_pixel, out_bus.last_pixel);
          case (want.result_kind)
            pnmbgr_pkg::KIND_PIXEL:  pixels_seen++;
            pnmbgr_pkg::KIND_HEADER: headers_seen++;
            default:                 bad_magic_seen++;
          endcase
        end
      end
    end
  end

  // abort when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("pnm_byte_stream_to_bgrx_pixels_core: mismatch");
      $finish;
    end
  end

  // result side: stall in stretches of varying density, hold off once for long
  initial begin
    int  stretch;
    int  mode;
    bit  held;
    held = 1'b0;
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stretch = $urandom_range(10, 60);
      mode    = $urandom_range(0, 3);
      repeat (stretch) begin
        @(negedge clk);
        if (!held && results_seen >= 120) begin
          held = 1'b1;
          out_bus.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= $urandom_range(0, 1);
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic add_row(input logic sof, input logic [7:0] d);
    stim_q.push_back('{sof, d, 1'b0, NO_RES});
  endtask

  task automatic add_checked(input logic sof, input logic [7:0] d,
                             input pnmbgr_pkg::res_t want);
    stim_q.push_back('{sof, d, 1'b1, want});
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    if (is_dec(b)) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic logic [7:0] not_lf();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    if (b == pnmbgr_pkg::CH_LF) b = 8'h20;
    return b;
  endfunction

  task automatic put_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) add_row(1'b0, s[i]);
  endtask

  task automatic put_separator();
    repeat ($urandom_range(1, 2))
      add_row(1'b0, ($urandom_range(0, 2) == 0) ? non_digit() : 8'h20);
  endtask

  // one file: mostly well formed with random content, some broken or noise
  task automatic build_file(output int counted);
    int          flavor;
    int unsigned w;
    int unsigned h;
    int unsigned nbytes;
    bit          color;
    logic [7:0]  b;
    stim_q.delete();
    flavor = $urandom_range(0, 19);
    color  = $urandom_range(0, 1);
    w      = $urandom_range(1, 6);
    h      = $urandom_range(1, 4);
    counted = 0;
    if (flavor == 17) begin
      // loose bytes, a few carrying a start mark
      repeat ($urandom_range(4, 12))
        add_row($urandom_range(0, 7) == 0, $urandom_range(0, 255));
    end else if (flavor == 16) begin
      // broken magic, then junk to drop
      b = $urandom_range(0, 255);
      if ($urandom_range(0, 1)) begin
        add_row(1'b1, pnmbgr_pkg::CH_P);
        if (b == pnmbgr_pkg::CH_FIVE || b == pnmbgr_pkg::CH_SIX) b = pnmbgr_pkg::CH_HASH;
        add_row(1'b0, b);
      end else begin
        if (b == pnmbgr_pkg::CH_P) b = pnmbgr_pkg::CH_FIVE;
        add_row(1'b1, b);
      end
      counted = stim_q.size();
      repeat ($urandom_range(0, 4)) add_row(1'b0, $urandom_range(0, 255));
    end else begin
      add_row(1'b1, pnmbgr_pkg::CH_P);
      add_row(1'b0, color ? pnmbgr_pkg::CH_SIX : pnmbgr_pkg::CH_FIVE);
      repeat ($urandom_range(0, 2)) add_row(1'b0, not_lf());
      add_row(1'b0, pnmbgr_pkg::CH_LF);
      repeat ($urandom_range(0, 2)) begin
        add_row(1'b0, pnmbgr_pkg::CH_HASH);
        repeat ($urandom_range(0, 5)) add_row(1'b0, not_lf());
        add_row(1'b0, pnmbgr_pkg::CH_LF);
      end
      case (flavor)
        12: if ($urandom_range(0, 1)) w = 0; else h = 0;
        13: begin
          if ($urandom_range(0, 1))
            w = $urandom_range(0, 1) ? DIM_MAX : $urandom_range(DIM_MAX + 1, 9999999);
          else
            h = $urandom_range(0, 1) ? DIM_MAX : $urandom_range(DIM_MAX + 1, 9999999);
        end
        18, 19: begin
          w = $urandom_range(1, 40);
          h = $urandom_range(1, 2);
        end
        default: ;
      endcase
      if (flavor == 14) begin
        // width line opens with a stray byte: width reads as zero
        b = non_digit();
        if (b == pnmbgr_pkg::CH_HASH) b = 8'h20;
        add_row(1'b0, b);
        w = 0;
      end else begin
        if ($urandom_range(0, 7) == 0) add_row(1'b0, pnmbgr_pkg::CH_ZERO);
        put_number(w);
        put_separator();
      end
      put_number(h);
      put_separator();
      put_number($urandom_range(1, DIM_MAX));
      repeat ($urandom_range(0, 1)) add_row(1'b0, not_lf());
      add_row(1'b0, pnmbgr_pkg::CH_LF);
      if (flavor == 13) nbytes = $urandom_range(3, 24);
      else nbytes = w * h * (color ? 3 : 1);
      repeat (nbytes) add_row(1'b0, $urandom_range(0, 255));
      if (flavor == 15) stim_q = stim_q[0 : $urandom_range(0, stim_q.size() - 2)];
      counted = stim_q.size();
      if (w == 0 || h == 0 || $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 5)) add_row(1'b0, $urandom_range(0, 255));
    end
  endtask

  // offer one beat, idling between bursts unless in a steady stretch
  task automatic offer_row(input stim_row_t row);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_in) gap = $urandom_range(0, 5);
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid         <= 1'b1;
    in_bus.start_of_file <= row.sof;
    in_bus.data_byte     <= row.data;
    cur_row              <= row;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
  endtask

  // drop valid and hold until every predicted result is out
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (due_results_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int counted;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.start_of_file = 1'b0;
    in_bus.data_byte     = '0;
    cur_row              = '0;
    err_count            = 0;
    results_seen         = 0;
    pixels_seen          = 0;
    headers_seen         = 0;
    bad_magic_seen       = 0;
    items_sent           = 0;
    files_sent           = 0;
    burst_left           = 0;
    steady_in            = 1'b0;
    clear_decoder();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: unmarked first file (P6, comment, 2x1, extreme samples)
    add_row(1'b0, pnmbgr_pkg::CH_P);
    add_row(1'b0, pnmbgr_pkg::CH_SIX);
    add_row(1'b0, pnmbgr_pkg::CH_LF);
    add_row(1'b0, pnmbgr_pkg::CH_HASH);
    add_row(1'b0, pnmbgr_pkg::CH_LF);
    add_row(1'b0, pnmbgr_pkg::CH_ZERO + 8'd2);
    add_row(1'b0, 8'h20);
    add_row(1'b0, pnmbgr_pkg::CH_ZERO + 8'd1);
    add_row(1'b0, pnmbgr_pkg::CH_LF);
    add_row(1'b0, pnmbgr_pkg::CH_NINE);
    add_checked(1'b0, pnmbgr_pkg::CH_LF,
                res_of(pnmbgr_pkg::KIND_HEADER, 8'd0, 8'd0, 8'd0, 16'd2, 16'd1, 1'b0));
    add_row(1'b0, 8'h00);
    add_row(1'b0, 8'hFF);
    add_row(1'b0, 8'h80);
    add_row(1'b0, 8'hFF);
    add_row(1'b0, 8'h00);
    add_checked(1'b0, 8'h01,
                res_of(pnmbgr_pkg::KIND_PIXEL, 8'h01, 8'h00, 8'hFF, 16'd2, 16'd1, 1'b1));
    // bad first byte, then bad second byte
    add_checked(1'b1, 8'h58,
                res_of(pnmbgr_pkg::KIND_BAD_MAGIC, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0));
    add_row(1'b1, pnmbgr_pkg::CH_P);
    add_checked(1'b0, pnmbgr_pkg::CH_ZERO + 8'd7,
                res_of(pnmbgr_pkg::KIND_BAD_MAGIC, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0));
    // P5 whose width line starts with a letter: zero width, empty image
    add_row(1'b1, pnmbgr_pkg::CH_P);
    add_row(1'b0, pnmbgr_pkg::CH_FIVE);
    add_row(1'b0, pnmbgr_pkg::CH_LF);
    add_row(1'b0, 8'h61);
    add_row(1'b0, pnmbgr_pkg::CH_ZERO + 8'd7);
    add_row(1'b0, pnmbgr_pkg::CH_LF);
    add_row(1'b0, pnmbgr_pkg::CH_ZERO + 8'd1);
    add_checked(1'b0, pnmbgr_pkg::CH_LF,
                res_of(pnmbgr_pkg::KIND_HEADER, 8'd0, 8'd0, 8'd0, 16'd0, 16'd7, 1'b0));
    foreach (stim_q[i]) offer_row(stim_q[i]);
    items_sent = stim_q.size();

    // random files until the byte budget is spent
    while (items_sent < ITEM_GOAL) begin
      build_file(counted);
      steady_in = ($urandom_range(0, 3) == 0);
      foreach (stim_q[i]) offer_row(stim_q[i]);
      items_sent += counted;
      files_sent++;
      if (files_sent == 6) drain_results();
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("covered %0d random files, %0d bytes offered; seen %0d pixels, %0d headers,",
             files_sent, items_sent, pixels_seen, headers_seen);
    $display("  %0d format errors, long output stall and full drain pause", bad_magic_seen);
    if (err_count == 0)
      $display("pnm_byte_stream_to_bgrx_pixels_core: match");
    else
      $display("pnm_byte_stream_to_bgrx_pixels_core: mismatch");
    $finish;
  end

endmodule
